// ===== rtl/eodt_pkg.sv =====
// Package for the earliest-deadline order table.
// Holds the table size, the request and status codes, the word that walks
// the cell chain and the saturating add. No dependencies.
`default_nettype none

package eodt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;
  localparam int DL_W        = 32;
  localparam int SLACK_W     = 16;

  localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(180);
  localparam logic [DL_W-1:0]    DL_MAX      = '1;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_RETRIEVE = 2'd1,
    REQ_POSTPONE = 2'd2,
    REQ_CANCEL   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BAD_ID = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_FULL   = 2'd3
  } status_t;

  // Request word handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             vld;
    req_t             req;
    logic [IDX_W-1:0] sel;       // target slot for add, postpone, cancel
    logic             sel_ok;    // target slot lies in the handed-out range
    logic [DL_W-1:0]  val;       // new deadline for add, seconds for postpone
    logic             hit;       // target slot was pending and acted on
    logic             best_vld;  // a pending slot has been seen
    logic [IDX_W-1:0] best_idx;
    logic [DL_W-1:0]  best_dl;   // running minimum, or the touched deadline
  } tok_t;

  function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                              input logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DL_W] ? DL_MAX : s[DL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/eodt_cell.sv =====
// One slot of the order table: pending flag and deadline.
// Acts on the request word as it passes and hands it on. Uses eodt_pkg.
`default_nettype none

module eodt_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [eodt_pkg::IDX_W-1:0] cell_idx,
  input  wire eodt_pkg::tok_t            tok_in,
  output eodt_pkg::tok_t                 tok_out,
  input  wire logic                      clr_en,
  input  wire logic [eodt_pkg::IDX_W-1:0] clr_idx
);

  logic                      pend_r, pend_nxt;
  logic [eodt_pkg::DL_W-1:0] dl_r, dl_nxt;
  logic                      target;
  logic [eodt_pkg::DL_W-1:0] dl_sum;

  assign target = tok_in.vld && tok_in.sel_ok && (tok_in.sel == cell_idx);
  assign dl_sum = eodt_pkg::sat_add(dl_r, tok_in.val);

  always_comb begin
    pend_nxt = pend_r;
    dl_nxt   = dl_r;
    tok_out  = tok_in;
    if (tok_in.vld) begin
      case (tok_in.req)
        eodt_pkg::REQ_ADD: begin
          if (target) begin
            pend_nxt = 1'b1;
            dl_nxt   = tok_in.val;
          end
        end
        eodt_pkg::REQ_RETRIEVE: begin
          // strict compare keeps the lowest slot on a tie
          if (pend_r && (!tok_in.best_vld || dl_r < tok_in.best_dl)) begin
            tok_out.best_vld = 1'b1;
            tok_out.best_idx = cell_idx;
            tok_out.best_dl  = dl_r;
          end
        end
        eodt_pkg::REQ_POSTPONE: begin
          if (target && pend_r) begin
            dl_nxt          = dl_sum;
            tok_out.hit     = 1'b1;
            tok_out.best_dl = dl_sum;
          end
        end
        eodt_pkg::REQ_CANCEL: begin
          if (target && pend_r) begin
            pend_nxt        = 1'b0;
            tok_out.hit     = 1'b1;
            tok_out.best_dl = dl_r;
          end
        end
        default: begin
          pend_nxt = pend_r;
        end
      endcase
    end
    // drop the slot picked by a finished retrieve
    if (clr_en && clr_idx == cell_idx) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/earliest_deadline_order_table.sv =====
// Earliest-deadline order table: a request word walks a row of cells, one
// cell per clock, and the result is formed when it leaves the last cell.
// The word is registered at accept and behind each cell, as is the result for
// the out_valid strobe. busy drops with the strobe; a request is taken only
// while idle. Reset (synchronous, rst_n low) clears all pending flags and both
// counters and sets the slack to 180; results cannot be held.
`default_nettype none

module earliest_deadline_order_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_order_id,
  input  wire logic [31:0] in_delivery_time,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_order_id_res,
  output logic [31:0]      out_deadline,
  output logic [7:0]       out_pending_count
);

  localparam int D = eodt_pkg::TABLE_DEPTH;
  localparam logic [eodt_pkg::CNT_W-1:0] DEPTH_C = eodt_pkg::CNT_W'(D);

  eodt_pkg::tok_t tok_r [0:D];
  eodt_pkg::tok_t cell_out [0:D-1];
  eodt_pkg::tok_t tok_load;
  eodt_pkg::tok_t tail;

  logic                          busy_r;
  logic [eodt_pkg::SLACK_W-1:0]  slack_r;
  logic [eodt_pkg::CNT_W-1:0]    next_slot_r, next_slot_nxt;
  logic [eodt_pkg::CNT_W-1:0]    total_r, total_nxt;
  logic                          accept;
  logic [eodt_pkg::CMP_W-1:0]    id_ext, id_m1, slot_ext;

  logic                          clr_en;
  logic                          res_vld_r;
  logic [1:0]                    res_sts_r, res_sts_nxt;
  logic [7:0]                    res_id_r, res_id_nxt;
  logic [31:0]                   res_dl_r, res_dl_nxt;
  logic [7:0]                    res_cnt_r;
  logic [eodt_pkg::CMP_W-1:0]    sel_p1, cnt_ext;

  assign accept   = start && !busy_r;
  assign busy     = busy_r;
  assign tail     = tok_r[D];
  assign id_ext   = eodt_pkg::CMP_W'(in_order_id);
  assign id_m1    = id_ext - eodt_pkg::CMP_W'(1);
  assign slot_ext = eodt_pkg::CMP_W'(next_slot_r);

  // build the request word at accept
  always_comb begin
    tok_load          = '0;
    tok_load.vld      = 1'b1;
    tok_load.req      = eodt_pkg::req_t'(in_req_type);
    tok_load.val      = in_delivery_time;
    case (eodt_pkg::req_t'(in_req_type))
      eodt_pkg::REQ_ADD: begin
        tok_load.sel    = next_slot_r[eodt_pkg::IDX_W-1:0];
        tok_load.sel_ok = (next_slot_r < DEPTH_C);
        tok_load.val    = eodt_pkg::sat_add(in_delivery_time,
                                            eodt_pkg::DL_W'(slack_r));
      end
      eodt_pkg::REQ_POSTPONE, eodt_pkg::REQ_CANCEL: begin
        tok_load.sel    = id_m1[eodt_pkg::IDX_W-1:0];
        tok_load.sel_ok = (in_order_id != 8'd0) && (id_ext <= slot_ext);
      end
      default: begin
        tok_load.sel_ok = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    eodt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(eodt_pkg::IDX_W'(g)),
      .tok_in  (tok_r[g]),
      .tok_out (cell_out[g]),
      .clr_en  (clr_en),
      .clr_idx (tail.best_idx)
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r[0].vld <= 1'b0;
    end else if (accept) begin
      tok_r[0] <= tok_load;
    end else begin
      tok_r[0].vld <= 1'b0;
    end
  end

  for (genvar s = 1; s <= D; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tok_r[s].vld <= 1'b0;
      end else begin
        tok_r[s] <= cell_out[s-1];
      end
    end
  end

  // form the result as the word leaves the last cell
  assign sel_p1 = eodt_pkg::CMP_W'(tail.sel) + eodt_pkg::CMP_W'(1);

  always_comb begin
    clr_en        = 1'b0;
    next_slot_nxt = next_slot_r;
    total_nxt     = total_r;
    res_sts_nxt   = eodt_pkg::STS_OK;
    res_id_nxt    = 8'd0;
    res_dl_nxt    = '0;
    if (tail.vld) begin
      case (tail.req)
        eodt_pkg::REQ_ADD: begin
          if (tail.sel_ok) begin
            res_id_nxt    = sel_p1[7:0];
            res_dl_nxt    = tail.val;
            next_slot_nxt = next_slot_r + eodt_pkg::CNT_W'(1);
            total_nxt     = total_r + eodt_pkg::CNT_W'(1);
          end else begin
            res_sts_nxt = eodt_pkg::STS_FULL;
          end
        end
        eodt_pkg::REQ_RETRIEVE: begin
          if (tail.best_vld) begin
            clr_en     = 1'b1;
            res_id_nxt = 8'(eodt_pkg::CMP_W'(tail.best_idx) + eodt_pkg::CMP_W'(1));
            res_dl_nxt = tail.best_dl;
            total_nxt  = total_r - eodt_pkg::CNT_W'(1);
          end else begin
            res_sts_nxt = eodt_pkg::STS_EMPTY;
          end
        end
        eodt_pkg::REQ_POSTPONE, eodt_pkg::REQ_CANCEL: begin
          if (tail.hit) begin
            res_id_nxt = sel_p1[7:0];
            res_dl_nxt = tail.best_dl;
            if (tail.req == eodt_pkg::REQ_CANCEL) begin
              total_nxt = total_r - eodt_pkg::CNT_W'(1);
            end
          end else begin
            res_sts_nxt = eodt_pkg::STS_BAD_ID;
          end
        end
        default: begin
          res_sts_nxt = eodt_pkg::STS_OK;
        end
      endcase
    end
  end

  assign cnt_ext = eodt_pkg::CMP_W'(total_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slack_r     <= eodt_pkg::SLACK_RESET;
      next_slot_r <= '0;
      total_r     <= '0;
      res_vld_r   <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (tail.vld) begin
        busy_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        slack_r <= cfg_wr_data;
      end
      next_slot_r <= next_slot_nxt;
      total_r     <= total_nxt;
      res_vld_r   <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      res_sts_r <= res_sts_nxt;
      res_id_r  <= res_id_nxt;
      res_dl_r  <= res_dl_nxt;
      res_cnt_r <= cnt_ext[7:0];
    end
  end

  assign out_valid         = res_vld_r;
  assign out_status        = res_sts_r;
  assign out_order_id_res  = res_id_r;
  assign out_deadline      = res_dl_r;
  assign out_pending_count = res_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/eodt_checker.sv =====
// Port-level checks for the earliest-deadline order table, bound to the top.
// Depends on eodt_pkg and earliest_deadline_order_table.
`default_nettype none

module eodt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_order_id_res,
  input wire logic [31:0] out_deadline
);

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // busy only drops together with the result strobe
  a_fell_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != eodt_pkg::STS_OK |->
      out_order_id_res == 8'd0 && out_deadline == 32'd0)
    else $error("failed request returned an id or deadline");

endmodule

bind earliest_deadline_order_table eodt_checker u_eodt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_order_id_res(out_order_id_res),
  .out_deadline    (out_deadline)
);

`default_nettype wire
